/* rtl/xmodem_crc_packet_framer_macros.svh */
// ----------------------------------------------------------------------------
// XMODEM-CRC framer assertion macros
// Shared concurrent assertion forms for the framer's RTL files.
// ----------------------------------------------------------------------------
`ifndef XMODEM_CRC_PACKET_FRAMER_MACROS_SVH
`define XMODEM_CRC_PACKET_FRAMER_MACROS_SVH

// Same-cycle implication, disabled while reset is low
`define XCRC_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low
`define XCRC_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/xcrc_pkg.sv */
// ----------------------------------------------------------------------------
// XMODEM-CRC framer package
// Block size, protocol constants, command record and the CRC byte fold.
// ----------------------------------------------------------------------------
package xcrc_pkg;

    localparam int BLOCK_BYTES = 128;
    localparam int FILL_W      = $clog2(BLOCK_BYTES);

    localparam logic [7:0]  START_BYTE = 8'h01;
    localparam logic [7:0]  PAD_RESET  = 8'h26;
    localparam logic [15:0] CRC_POLY   = 16'h1021;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    // Output sequencer positions, in emission order
    localparam logic [2:0] PH_SOH  = 3'd0;
    localparam logic [2:0] PH_BLK  = 3'd1;
    localparam logic [2:0] PH_NBLK = 3'd2;
    localparam logic [2:0] PH_DATA = 3'd3;
    localparam logic [2:0] PH_CRCH = 3'd4;
    localparam logic [2:0] PH_CRCL = 3'd5;

    typedef struct packed {
        logic [7:0]  data;     // payload or pad byte
        logic        hdr;      // open a block: header goes first
        logic        crc_end;  // close the block: CRC goes after
        logic [7:0]  blk;      // block number of this block
        logic [15:0] crc;      // CRC including this byte
    } t_cmd;

    // CRC-16, poly 0x1021, MSB first, one byte
    function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

endpackage

/* rtl/xcrc_front.sv */
// ----------------------------------------------------------------------------
// XMODEM-CRC framer front end
// Accepts input items, tracks block fill, number and CRC, and queues one
// command per item that produces output.
// ----------------------------------------------------------------------------
module xcrc_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic          i_opcode,
    input  logic [7:0]    i_data_byte,
    input  logic          i_cfg_we,
    input  logic [7:0]    i_cfg_wdata,
    input  logic          i_q_full,
    output logic          o_push,
    output xcrc_pkg::t_cmd o_cmd
);
    import xcrc_pkg::*;

    logic [7:0]        r_pad;
    logic [FILL_W-1:0] r_fill;
    logic [7:0]        r_blk;
    logic [15:0]       r_crc;

    logic [FILL_W-1:0] n_fill;
    logic [7:0]        n_blk;

    logic              open_blk;
    logic              accept;
    logic [7:0]        byte_in;
    logic [15:0]       crc_new;
    logic [FILL_W:0]   fill_inc;
    logic              closes;

    assign o_ready  = !i_q_full;
    assign accept   = i_valid && o_ready;
    assign open_blk = (r_fill != '0);
    assign byte_in  = i_opcode ? r_pad : i_data_byte;
    assign crc_new  = crc_fold(open_blk ? r_crc : 16'h0000, byte_in);
    assign fill_inc = {1'b0, r_fill} + (FILL_W+1)'(1);
    assign closes   = (fill_inc >= (FILL_W+1)'(BLOCK_BYTES));

    // drop a pad item when no block is open
    assign o_push = accept && !(i_opcode && !open_blk);

    assign o_cmd.data    = byte_in;
    assign o_cmd.hdr     = !open_blk;
    assign o_cmd.crc_end = closes;
    assign o_cmd.blk     = r_blk;
    assign o_cmd.crc     = crc_new;

    assign n_fill = closes ? '0 : fill_inc[FILL_W-1:0];
    assign n_blk  = closes ? r_blk + 8'd1 : r_blk;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pad  <= PAD_RESET;
            r_fill <= '0;
            r_blk  <= 8'd1;
            r_crc  <= 16'h0000;
        end else begin
            if (i_cfg_we) begin
                r_pad <= i_cfg_wdata;
            end
            if (o_push) begin
                r_fill <= n_fill;
                r_blk  <= n_blk;
                r_crc  <= crc_new;
            end
        end
    end

endmodule

/* rtl/xcrc_fifo.sv */
// ----------------------------------------------------------------------------
// XMODEM-CRC framer command queue
// Small first-in first-out store between the front end and the emitter.
// ----------------------------------------------------------------------------
`include "xmodem_crc_packet_framer_macros.svh"

module xcrc_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  xcrc_pkg::t_cmd i_data,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output xcrc_pkg::t_cmd o_data
);
    import xcrc_pkg::*;

    t_cmd           r_mem [QDEPTH];
    logic [QAW-1:0] r_wr;
    logic [QAW-1:0] r_rd;
    logic [QAW:0]   r_count;

    logic [QAW:0]   n_count;

    assign o_full  = (r_count == (QAW+1)'(QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + (QAW+1)'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - (QAW+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + QAW'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + QAW'(1);
            end
            r_count <= n_count;
        end
    end

    `XCRC_ASSERT_IMP(a_no_push_full, i_clk, i_rst_n, i_push, !o_full || i_pop, "push into full queue")
    `XCRC_ASSERT_IMP(a_no_pop_empty, i_clk, i_rst_n, i_pop, o_valid, "pop from empty queue")

endmodule

/* rtl/xcrc_back.sv */
// ----------------------------------------------------------------------------
// XMODEM-CRC framer emitter
// Expands each queued command into header, data and CRC bytes, one byte per
// cycle while a command waits and the output is ready, through a registered output stage.
// ----------------------------------------------------------------------------
`include "xmodem_crc_packet_framer_macros.svh"

module xcrc_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    input  xcrc_pkg::t_cmd i_cmd,
    output logic           o_pop,
    output logic           o_tvalid,
    input  logic           i_tready,
    output logic [7:0]     o_tdata,
    output logic           o_tlast,
    output logic           o_tuser
);
    import xcrc_pkg::*;

    logic       r_tvalid;
    logic [7:0] r_tdata;
    logic       r_tlast;
    logic       r_tuser;
    logic       r_first;
    logic [2:0] r_phase;

    logic       n_tvalid;
    logic       n_first;
    logic [2:0] n_phase;

    logic       load;
    logic [2:0] ph;
    logic [7:0] byte_out;
    logic       last;

    assign load = i_q_valid && (!r_tvalid || i_tready);
    assign ph   = r_first ? (i_cmd.hdr ? PH_SOH : PH_DATA) : r_phase;
    assign last = ((ph == PH_DATA) && !i_cmd.crc_end) || (ph == PH_CRCL);
    assign o_pop = load && last;

    always_comb begin
        unique case (ph)
            PH_SOH:  byte_out = START_BYTE;
            PH_BLK:  byte_out = i_cmd.blk;
            PH_NBLK: byte_out = ~i_cmd.blk;
            PH_DATA: byte_out = i_cmd.data;
            PH_CRCH: byte_out = i_cmd.crc[15:8];
            PH_CRCL: byte_out = i_cmd.crc[7:0];
            default: byte_out = 8'h00;
        endcase
    end

    always_comb begin
        n_tvalid = r_tvalid;
        n_first  = r_first;
        n_phase  = r_phase;
        if (load) begin
            n_tvalid = 1'b1;
            n_first  = last;
            n_phase  = ph + 3'd1;
        end else if (i_tready) begin
            n_tvalid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_tdata <= byte_out;
            r_tlast <= last;
            r_tuser <= (ph == PH_CRCL);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tvalid <= 1'b0;
            r_first  <= 1'b1;
            r_phase  <= PH_SOH;
        end else begin
            r_tvalid <= n_tvalid;
            r_first  <= n_first;
            r_phase  <= n_phase;
        end
    end

    assign o_tvalid = r_tvalid;
    assign o_tdata  = r_tdata;
    assign o_tlast  = r_tlast;
    assign o_tuser  = r_tuser;

    `XCRC_ASSERT_IMP(a_end_is_last, i_clk, i_rst_n, r_tvalid && r_tuser, r_tlast, "block end without last")
    `XCRC_ASSERT_NXT(a_soh_byte, i_clk, i_rst_n, load && (ph == PH_SOH), r_tdata == START_BYTE, "bad start byte")
    `XCRC_ASSERT_IMP(a_mid_item, i_clk, i_rst_n, !r_first, i_q_valid, "command left mid item")

endmodule

/* rtl/xmodem_crc_packet_framer.sv */
// ----------------------------------------------------------------------------
// XMODEM-CRC packet framer
// Cuts a byte stream into XMODEM-CRC blocks with header and CRC-16 trailer.
// ----------------------------------------------------------------------------
// Each input item is accepted by the front end, which updates the block
// state and queues a command (up to four commands wait in the queue). The
// emitter sends one byte per cycle from its output register while a command
// waits and the output port is ready; an item produces one byte inside a block,
// four for the byte that opens a block (start byte, number, complement, data)
// and three for the byte that closes it (data, CRC high, CRC low); a pad item
// with no open block produces no output. For 128-byte blocks the emitter port
// sets the throughput.
module xmodem_crc_packet_framer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_wdata,     // pad_value
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,    // [7:0] data_byte
    input  logic       s_axis_tuser,    // [0] opcode
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,    // [7:0] out_byte
    output logic       m_axis_tlast,
    output logic       m_axis_tuser     // [0] block_end
);
    import xcrc_pkg::*;

    t_cmd push_cmd;
    t_cmd head_cmd;
    logic push;
    logic pop;
    logic q_full;
    logic q_valid;

    xcrc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_opcode    (s_axis_tuser),
        .i_data_byte (s_axis_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_cmd       (push_cmd)
    );

    xcrc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_cmd),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_data  (head_cmd)
    );

    xcrc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_cmd     (head_cmd),
        .o_pop     (pop),
        .o_tvalid  (m_axis_tvalid),
        .i_tready  (m_axis_tready),
        .o_tdata   (m_axis_tdata),
        .o_tlast   (m_axis_tlast),
        .o_tuser   (m_axis_tuser)
    );

endmodule
